[rtl/y86f_pkg.sv]
// Shared types, codes and defaults for the Y86 fetch stage.
`default_nettype none

package y86f_pkg;

  localparam int unsigned STORE_NIBBLES_DEF = 4096;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_STEP    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [3:0] I_HALT   = 4'd0;
  localparam logic [3:0] I_NOP    = 4'd1;
  localparam logic [3:0] I_RRMOV  = 4'd2;
  localparam logic [3:0] I_IRMOV  = 4'd3;
  localparam logic [3:0] I_RMMOV  = 4'd4;
  localparam logic [3:0] I_MRMOV  = 4'd5;
  localparam logic [3:0] I_OPL    = 4'd6;
  localparam logic [3:0] I_JXX    = 4'd7;
  localparam logic [3:0] I_CALL   = 4'd8;
  localparam logic [3:0] I_RET    = 4'd9;
  localparam logic [3:0] I_PUSH   = 4'd10;
  localparam logic [3:0] I_POP    = 4'd11;

  localparam logic [3:0] REG_NONE = 4'hF;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_HALT = 2'd1;
  localparam logic [1:0] STAT_INS  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  load_nibble;
    logic [3:0]  mem_icode;
    logic        mem_cnd;
    logic [11:0] mem_vala;
    logic [3:0]  wb_icode;
    logic [11:0] wb_valm;
    logic [3:0]  ex_icode;
    logic        ex_cnd;
    logic [3:0]  ex_dstm;
    logic [3:0]  dec_srca;
    logic [3:0]  dec_srcb;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  icode;
    logic [3:0]  ifun;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [31:0] const_val;
    logic [11:0] next_pc;
    logic [11:0] pc;
    logic [11:0] pred_pc;
  } res_t;

endpackage

`default_nettype wire

[rtl/y86f_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module y86f_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/y86_fetch_stage.sv]
// Top level of the Y86 fetch stage: store loading, PC selection and decode.
//
// A command word is taken on req_i when start is high and busy is low.
// A load word writes one nibble at the load pointer in that same cycle and
// leaves busy low. A restart word clears the PC and the pending return and
// stall flags. A step word raises busy while the sequencer selects the PC,
// reads the instruction nibble by nibble from the store, or takes a nop for a
// bubble, and forms the prediction; the result word then appears on res_o for
// exactly one cycle with valid_o high. The receiver cannot stall.
// A step reads one nibble a cycle through the store's single read port, up to
// twelve nibbles. With a store size that is not a power of two each address
// taken from the stage inputs or the constant word is reduced by one restoring
// compare-and-subtract step a cycle, 33 - log2 rounded up of the size steps.
// Reset clears the PC, the prediction, the load pointer and the flags; the
// store contents are not cleared and must be loaded before they are fetched.
`default_nettype none

module y86_fetch_stage
  import y86f_pkg::*;
#(
  parameter int unsigned STORE_NIBBLES = STORE_NIBBLES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire req_t req_i,
  output logic      busy,
  output logic      valid_o,
  output res_t      res_o
);

  localparam int unsigned AW   = $clog2(STORE_NIBBLES);
  localparam bit          POW2 = (STORE_NIBBLES == (1 << AW));
  localparam int unsigned KMAX = 32 - AW;
  localparam int unsigned KW   = $clog2(KMAX + 1);
  localparam int unsigned XW   = (AW > 12) ? AW : 12;
  localparam logic [32:0] NBIG = 33'(STORE_NIBBLES);
  localparam logic [AW:0] NEXT = (AW + 1)'(STORE_NIBBLES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a, input logic [3:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + (AW + 1)'(b);
    if (s >= NEXT) begin
      s = s - NEXT;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [11:0] to12(input logic [AW-1:0] a);
    logic [XW-1:0] t;
    t = XW'(a);
    return t[11:0];
  endfunction

  function automatic logic [3:0] instr_len(input logic [3:0] ic);
    logic [3:0] n;
    unique case (ic) inside
      I_RRMOV, I_OPL, I_PUSH, I_POP: n = 4'd4;
      I_IRMOV, I_RMMOV, I_MRMOV:     n = 4'd12;
      I_JXX, I_CALL:                 n = 4'd10;
      default:                       n = 4'd2;
    endcase
    return n;
  endfunction

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] pc_q, pc_d, pred_q, pred_d, lp_q, lp_d;
  logic          retp_q, retp_d, stall_q, stall_d;
  logic          bubble_q, bubble_d, tgt_q, tgt_d;
  logic [31:0]   rem_q, rem_d;
  logic [KW-1:0] k_q, k_d;
  logic [3:0]    cnt_q, cnt_d, rc_q, rc_d;
  logic          rv_q, rv_d;
  logic [3:0]    icode_q, icode_d, ifun_q, ifun_d, ra_q, ra_d, rb_q, rb_d;
  logic [31:0]   cval_q, cval_d;
  logic [AW-1:0] npc_q, npc_d;
  logic [1:0]    status_q, status_d;
  logic          valid_q, valid_d;
  res_t          res_q, res_d;

  logic          accept, mis, retw, lu_cond;
  logic          ram_we;
  logic [AW-1:0] raddr;
  logic [3:0]    rdata;
  logic [32:0]   nshift;
  logic [31:0]   rem_sub;
  logic [AW-1:0] red_res;
  logic          red_done;
  logic [3:0]    ws, wj, inc;
  logic [2:0]    widx;
  logic          has_word;

  y86f_ram #(
    .WIDTH(4),
    .DEPTH(STORE_NIBBLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(lp_q),
    .wdata_i(req_i.load_nibble),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign accept  = start && !busy;
  assign ram_we  = accept && (req_i.func == FUNC_LOAD);
  assign mis     = (req_i.mem_icode == I_JXX) && !req_i.mem_cnd;
  assign retw    = req_i.wb_icode == I_RET;
  assign lu_cond = ((req_i.ex_icode == I_MRMOV) || (req_i.ex_icode == I_POP)) &&
                   ((req_i.ex_dstm == req_i.dec_srca) || (req_i.ex_dstm == req_i.dec_srcb));

  assign nshift   = NBIG << k_q;
  assign rem_sub  = ({1'b0, rem_q} >= nshift) ? (rem_q - nshift[31:0]) : rem_q;
  assign red_res  = POW2 ? rem_q[AW-1:0] : rem_sub[AW-1:0];
  assign red_done = POW2 || (k_q == '0);

  assign has_word = (icode_q == I_IRMOV) || (icode_q == I_RMMOV) || (icode_q == I_MRMOV) ||
                    (icode_q == I_JXX) || (icode_q == I_CALL);
  assign ws   = ((icode_q == I_JXX) || (icode_q == I_CALL)) ? 4'd2 : 4'd4;
  assign wj   = rc_q - ws;
  assign widx = {wj[2:1], ~wj[0]};

  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    pred_d   = pred_q;
    lp_d     = lp_q;
    retp_d   = retp_q;
    stall_d  = stall_q;
    bubble_d = bubble_q;
    tgt_d    = tgt_q;
    rem_d    = rem_q;
    k_d      = k_q;
    cnt_d    = cnt_q;
    rc_d     = rc_q;
    rv_d     = 1'b0;
    icode_d  = icode_q;
    ifun_d   = ifun_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    cval_d   = cval_q;
    npc_d    = npc_q;
    status_d = status_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    raddr    = add_wrap(pc_q, cnt_q);
    inc      = 4'd0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.func)
            FUNC_LOAD: begin
              lp_d = add_wrap(lp_q, 4'd1);
            end
            FUNC_RESTART: begin
              pc_d    = '0;
              retp_d  = 1'b0;
              stall_d = 1'b0;
            end
            FUNC_STEP: begin
              bubble_d = (req_i.ex_icode == I_JXX) && !req_i.ex_cnd;
              stall_d  = lu_cond || (stall_q && (mis || retw));
              ra_d     = REG_NONE;
              rb_d     = REG_NONE;
              cval_d   = '0;
              cnt_d    = '0;
              tgt_d    = 1'b0;
              k_d      = KW'(KMAX);
              if (mis) begin
                rem_d   = 32'(req_i.mem_vala);
                state_d = S_RED;
              end else if (retw) begin
                rem_d   = 32'(req_i.wb_valm);
                retp_d  = 1'b0;
                state_d = S_RED;
              end else if (stall_q) begin
                state_d = S_READ;
              end else begin
                pc_d    = pred_q;
                state_d = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RED: begin
        rem_d = rem_sub;
        k_d   = k_q - KW'(1);
        if (red_done) begin
          if (!tgt_q) begin
            pc_d    = red_res;
            state_d = S_READ;
          end else begin
            pred_d  = red_res;
            valid_d = 1'b1;
            res_d   = '{status: status_q, icode: icode_q, ifun: ifun_q, reg_a: ra_q,
                        reg_b: rb_q, const_val: cval_q, next_pc: to12(npc_q),
                        pc: to12(pc_q), pred_pc: to12(red_res)};
            state_d = S_IDLE;
          end
        end
      end

      S_READ: begin
        if (bubble_q) begin
          icode_d = I_NOP;
          ifun_d  = 4'd0;
          state_d = S_FIN;
        end else begin
          if ((cnt_q < 4'd2) || (cnt_q < instr_len(icode_q))) begin
            rv_d  = 1'b1;
            rc_d  = cnt_q;
            cnt_d = cnt_q + 4'd1;
          end
          if (rv_q) begin
            if (rc_q == 4'd0) begin
              icode_d = rdata;
            end else if (rc_q == 4'd1) begin
              ifun_d = rdata;
            end else begin
              if (instr_len(icode_q) != 4'd10) begin
                if (rc_q == 4'd2) begin
                  ra_d = rdata;
                end
                if (rc_q == 4'd3) begin
                  rb_d = rdata;
                end
              end
              if (has_word && (rc_q >= ws)) begin
                cval_d[{widx, 2'b00} +: 4] = rdata;
              end
            end
            if ((rc_q != 4'd0) && (rc_q == instr_len(icode_q) - 4'd1)) begin
              state_d = S_FIN;
            end
          end
        end
      end

      S_FIN: begin
        status_d = STAT_OK;
        case (icode_q) inside
          I_HALT: begin
            inc      = 4'd2;
            status_d = STAT_HALT;
          end
          I_NOP:                          inc = retp_q ? 4'd0 : 4'd2;
          I_RRMOV, I_OPL, I_PUSH, I_POP:  inc = 4'd4;
          I_IRMOV, I_RMMOV, I_MRMOV:      inc = 4'd12;
          I_JXX, I_CALL:                  inc = 4'd10;
          I_RET: begin
            inc    = 4'd2;
            retp_d = 1'b1;
          end
          default: begin
            inc      = 4'd0;
            status_d = STAT_INS;
          end
        endcase
        npc_d = add_wrap(pc_q, inc);
        if ((icode_q == I_JXX) || (icode_q == I_CALL)) begin
          rem_d   = cval_q;
          k_d     = KW'(KMAX);
          tgt_d   = 1'b1;
          state_d = S_RED;
        end else begin
          pred_d  = npc_d;
          valid_d = 1'b1;
          res_d   = '{status: status_d, icode: icode_q, ifun: ifun_q, reg_a: ra_q,
                      reg_b: rb_q, const_val: cval_q, next_pc: to12(npc_d),
                      pc: to12(pc_q), pred_pc: to12(npc_d)};
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      pred_q  <= '0;
      lp_q    <= '0;
      retp_q  <= 1'b0;
      stall_q <= 1'b0;
      rv_q    <= 1'b0;
      cnt_q   <= '0;
      tgt_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      pred_q  <= pred_d;
      lp_q    <= lp_d;
      retp_q  <= retp_d;
      stall_q <= stall_d;
      rv_q    <= rv_d;
      cnt_q   <= cnt_d;
      tgt_q   <= tgt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bubble_q <= bubble_d;
    rem_q    <= rem_d;
    k_q      <= k_d;
    rc_q     <= rc_d;
    icode_q  <= icode_d;
    ifun_q   <= ifun_d;
    ra_q     <= ra_d;
    rb_q     <= rb_d;
    cval_q   <= cval_d;
    npc_q    <= npc_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  assign busy    = state_q != S_IDLE;
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the Y86 fetch stage: store preload, directed table, random programs.
`timescale 1ns / 100ps

module tb_top;
  import y86f_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [3:0] I_NONE = 4'hF;
  localparam logic [3:0] I_BAD = 4'hC;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1100;
  localparam logic [127:0] PRELUDE = 128'h001090C580FFFFFFFF30F201000000FF;

  typedef struct {
    req_t word;
    bit   typed;
    res_t want;
  } row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic valid_o;
  res_t res_o;

  logic [3:0] imem [0:STORE_NIBBLES_DEF-1];
  logic [11:0] ld_ptr = '0;
  logic [11:0] cur_pc = '0;
  logic [11:0] guess_pc = '0;
  bit ret_wait = 1'b0;
  bit hold_wait = 1'b0;

  res_t fetch_q[$];
  row_t dir_rows[$];
  res_t mon_want;
  int errs = 0;
  int n_items = 0;
  int burst_left = 1;
  int idle_cycles = 0;

  y86_fetch_stage uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic req_t mk_req(logic [1:0] f, logic [3:0] nib, logic [3:0] mi, logic mc,
                                  logic [11:0] mv, logic [3:0] wi, logic [11:0] wv,
                                  logic [3:0] ei, logic ec, logic [3:0] ed, logic [3:0] sa,
                                  logic [3:0] sb);
    return {f, nib, mi, mc, mv, wi, wv, ei, ec, ed, sa, sb};
  endfunction

  function automatic res_t mk_res(logic [1:0] st, logic [3:0] ic, logic [3:0] fn,
                                  logic [3:0] ra, logic [3:0] rb, logic [31:0] cv,
                                  logic [11:0] np, logic [11:0] p, logic [11:0] pp);
    return {st, ic, fn, ra, rb, cv, np, p, pp};
  endfunction

  function automatic req_t idle_step();
    return mk_req(FUNC_STEP, 4'd0, I_NONE, 1'b0, 12'd0, I_NONE, 12'd0, I_NONE, 1'b0, 4'd0,
                  REG_NONE, REG_NONE);
  endfunction

  function automatic void add_row(req_t w, bit typed, res_t want);
    row_t r;
    r.word = w;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [31:0] word_at(logic [11:0] p, logic [11:0] off);
    logic [31:0] v;
    logic [11:0] a;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      a = p + off + 12'(2 * k);
      v[8*k+4 +: 4] = imem[a];
      v[8*k +: 4] = imem[a + 12'd1];
    end
    return v;
  endfunction

  task automatic fetch_and_decode(input req_t w, output bit has_res, output res_t r);
    logic [3:0] op;
    logic [3:0] fn;
    logic [11:0] p;
    has_res = 1'b0;
    r = '0;
    case (w.func)
      FUNC_LOAD: begin
        imem[ld_ptr] = w.load_nibble;
        ld_ptr = ld_ptr + 12'd1;
      end
      FUNC_RESTART: begin
        cur_pc = '0;
        ret_wait = 1'b0;
        hold_wait = 1'b0;
      end
      FUNC_STEP: begin
        if (w.mem_icode == I_JXX && !w.mem_cnd) begin
          cur_pc = w.mem_vala;
        end else if (w.wb_icode == I_RET) begin
          cur_pc = w.wb_valm;
          ret_wait = 1'b0;
        end else if (hold_wait) begin
          hold_wait = 1'b0;
        end else begin
          cur_pc = guess_pc;
        end
        p = cur_pc;
        if (w.ex_icode == I_JXX && !w.ex_cnd) begin
          op = I_NOP;
          fn = 4'd0;
        end else begin
          op = imem[p];
          fn = imem[p + 12'd1];
        end
        r.status = STAT_OK;
        r.icode = op;
        r.ifun = fn;
        r.reg_a = REG_NONE;
        r.reg_b = REG_NONE;
        r.const_val = '0;
        r.pc = p;
        case (op)
          I_HALT: begin
            r.status = STAT_HALT;
            r.next_pc = p + 12'd2;
          end
          I_NOP: r.next_pc = ret_wait ? p : p + 12'd2;
          I_RRMOV, I_OPL, I_PUSH, I_POP: begin
            r.reg_a = imem[p + 12'd2];
            r.reg_b = imem[p + 12'd3];
            r.next_pc = p + 12'd4;
          end
          I_IRMOV, I_RMMOV, I_MRMOV: begin
            r.reg_a = imem[p + 12'd2];
            r.reg_b = imem[p + 12'd3];
            r.const_val = word_at(p, 12'd4);
            r.next_pc = p + 12'd12;
          end
          I_JXX, I_CALL: begin
            r.const_val = word_at(p, 12'd2);
            r.next_pc = p + 12'd10;
          end
          I_RET: begin
            r.next_pc = p + 12'd2;
            ret_wait = 1'b1;
          end
          default: begin
            r.status = STAT_INS;
            r.next_pc = p;
          end
        endcase
        if ((w.ex_icode == I_MRMOV || w.ex_icode == I_POP) &&
            (w.ex_dstm == w.dec_srca || w.ex_dstm == w.dec_srcb)) begin
          hold_wait = 1'b1;
        end
        r.pred_pc = (op == I_JXX || op == I_CALL) ? r.const_val[11:0] : r.next_pc;
        guess_pc = r.pred_pc;
        has_res = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input req_t w, input bit typed, input res_t want);
    bit has_res;
    res_t r;
    int gap;
    start <= 1'b1;
    req_i <= w;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    fetch_and_decode(w, has_res, r);
    if (has_res) fetch_q.push_back(typed ? want : r);
    if (w.func != FUNC_SPARE) n_items++;
    if (burst_left <= 1) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  function automatic req_t rand_stage();
    req_t w;
    int r;
    w.func = FUNC_STEP;
    w.load_nibble = 4'($urandom);
    r = $urandom_range(0, 9);
    w.mem_icode = (r == 0) ? I_JXX : (r < 7) ? I_NONE : 4'($urandom);
    w.mem_cnd = 1'($urandom);
    w.mem_vala = 12'($urandom);
    r = $urandom_range(0, 9);
    w.wb_icode = (r == 0) ? I_RET : (r < 7) ? I_NONE : 4'($urandom);
    w.wb_valm = 12'($urandom);
    r = $urandom_range(0, 9);
    w.ex_icode = (r == 0) ? I_JXX : (r == 1) ? I_MRMOV : (r == 2) ? I_POP :
                 (r < 7) ? I_NONE : 4'($urandom);
    w.ex_cnd = 1'($urandom);
    w.ex_dstm = 4'($urandom);
    w.dec_srca = ($urandom_range(0, 5) == 0) ? w.ex_dstm : 4'($urandom);
    w.dec_srcb = ($urandom_range(0, 5) == 0) ? w.ex_dstm : 4'($urandom);
    return w;
  endfunction

  task automatic load_nibble(input logic [3:0] nib);
    req_t w;
    w = rand_stage();
    w.func = FUNC_LOAD;
    w.load_nibble = nib;
    send_word(w, 1'b0, '0);
  endtask

  task automatic run_program();
    logic [3:0] op;
    logic [11:0] at;
    int len;
    req_t w;
    at = ld_ptr;
    op = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
    case (op)
      I_RRMOV, I_OPL, I_PUSH, I_POP: len = 4;
      I_IRMOV, I_RMMOV, I_MRMOV: len = 12;
      I_JXX, I_CALL: len = 10;
      default: len = 2;
    endcase
    load_nibble(op);
    repeat (len - 1) load_nibble(4'($urandom));
    w = rand_stage();
    if ($urandom_range(0, 1) == 0) begin
      w.mem_icode = I_JXX;
      w.mem_cnd = 1'b0;
      w.mem_vala = at;
    end else begin
      w.mem_icode = I_NONE;
      w.wb_icode = I_RET;
      w.wb_valm = at;
    end
    send_word(w, 1'b0, '0);
    repeat ($urandom_range(0, 4)) send_word(rand_stage(), 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      if (fetch_q.size() == 0) begin
        $error("fetch word with none expected: 0x%0h", res_o);
        errs++;
      end else begin
        mon_want = fetch_q.pop_front();
        check_field("status", 32'(mon_want.status), 32'(res_o.status));
        check_field("icode", 32'(mon_want.icode), 32'(res_o.icode));
        check_field("ifun", 32'(mon_want.ifun), 32'(res_o.ifun));
        check_field("reg_a", 32'(mon_want.reg_a), 32'(res_o.reg_a));
        check_field("reg_b", 32'(mon_want.reg_b), 32'(res_o.reg_b));
        check_field("const_val", mon_want.const_val, res_o.const_val);
        check_field("next_pc", 32'(mon_want.next_pc), 32'(res_o.next_pc));
        check_field("pc", 32'(mon_want.pc), 32'(res_o.pc));
        check_field("pred_pc", 32'(mon_want.pred_pc), 32'(res_o.pred_pc));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || valid_o === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    req_t w;
    int r;

    // The preload fills every entry, so no fetch ever reads an unwritten one.
    add_row(idle_step(), 1'b1,
            mk_res(STAT_HALT, I_HALT, 4'd0, REG_NONE, REG_NONE, 32'd0, 12'd2, 12'd0, 12'd2));
    add_row(idle_step(), 1'b1,
            mk_res(STAT_OK, I_NOP, 4'd0, REG_NONE, REG_NONE, 32'd0, 12'd4, 12'd2, 12'd4));
    add_row(idle_step(), 1'b1,
            mk_res(STAT_OK, I_RET, 4'd0, REG_NONE, REG_NONE, 32'd0, 12'd6, 12'd4, 12'd6));
    add_row(idle_step(), 1'b1,
            mk_res(STAT_INS, I_BAD, 4'd5, REG_NONE, REG_NONE, 32'd0, 12'd6, 12'd6, 12'd6));
    w = idle_step();
    w.ex_icode = I_JXX;
    add_row(w, 1'b1,
            mk_res(STAT_OK, I_NOP, 4'd0, REG_NONE, REG_NONE, 32'd0, 12'd6, 12'd6, 12'd6));
    w = idle_step();
    w.wb_icode = I_RET;
    w.wb_valm = 12'd8;
    w.ex_icode = I_MRMOV;
    w.ex_dstm = REG_NONE;
    add_row(w, 1'b1, mk_res(STAT_OK, I_CALL, 4'd0, REG_NONE, REG_NONE, 32'hFFFF_FFFF,
                            12'd18, 12'd8, 12'hFFF));
    add_row(idle_step(), 1'b1, mk_res(STAT_OK, I_CALL, 4'd0, REG_NONE, REG_NONE, 32'hFFFF_FFFF,
                                      12'd18, 12'd8, 12'hFFF));
    w = idle_step();
    w.mem_icode = I_JXX;
    w.mem_vala = 12'd18;
    w.wb_icode = I_RET;
    w.wb_valm = 12'hFFF;
    w.ex_icode = I_POP;
    w.ex_dstm = 4'd3;
    w.dec_srcb = 4'd3;
    add_row(w, 1'b1,
            mk_res(STAT_OK, I_IRMOV, 4'd0, REG_NONE, 4'd2, 32'd1, 12'd30, 12'd18, 12'd30));
    w = idle_step();
    w.wb_icode = I_RET;
    w.wb_valm = 12'd30;
    add_row(w, 1'b1,
            mk_res(STAT_INS, I_NONE, 4'hF, REG_NONE, REG_NONE, 32'd0, 12'd30, 12'd30, 12'd30));
    add_row(idle_step(), 1'b1,
            mk_res(STAT_INS, I_NONE, 4'hF, REG_NONE, REG_NONE, 32'd0, 12'd30, 12'd30, 12'd30));
    w = idle_step();
    w.mem_icode = I_JXX;
    w.mem_vala = 12'hFFF;
    add_row(w, 1'b0, '0);
    w = idle_step();
    w.func = FUNC_RESTART;
    add_row(w, 1'b0, '0);
    add_row('1, 1'b0, '0);
    add_row(idle_step(), 1'b0, '0);
    w = idle_step();
    w.mem_icode = I_JXX;
    w.mem_cnd = 1'b1;
    w.wb_icode = I_RET;
    add_row(w, 1'b1,
            mk_res(STAT_HALT, I_HALT, 4'd0, REG_NONE, REG_NONE, 32'd0, 12'd2, 12'd0, 12'd2));
    w = idle_step();
    w.ex_icode = I_MRMOV;
    w.ex_dstm = 4'd2;
    w.dec_srca = 4'd2;
    add_row(w, 1'b1,
            mk_res(STAT_OK, I_NOP, 4'd0, REG_NONE, REG_NONE, 32'd0, 12'd4, 12'd2, 12'd4));
    w = idle_step();
    w.func = FUNC_RESTART;
    add_row(w, 1'b0, '0);
    add_row(idle_step(), 1'b1,
            mk_res(STAT_OK, I_RET, 4'd0, REG_NONE, REG_NONE, 32'd0, 12'd6, 12'd4, 12'd6));
    w = idle_step();
    w.func = FUNC_RESTART;
    add_row(w, 1'b0, '0);
    w = idle_step();
    w.ex_icode = I_JXX;
    add_row(w, 1'b1,
            mk_res(STAT_OK, I_NOP, 4'd0, REG_NONE, REG_NONE, 32'd0, 12'd8, 12'd6, 12'd8));
    add_row(idle_step(), 1'b0, '0);
    w = idle_step();
    w.wb_icode = I_RET;
    w.wb_valm = 12'hFFF;
    w.ex_icode = I_JXX;
    add_row(w, 1'b1,
            mk_res(STAT_OK, I_NOP, 4'd0, REG_NONE, REG_NONE, 32'd0, 12'd1, 12'hFFF, 12'd1));
    add_row(mk_req(FUNC_STEP, 4'hF, I_JXX, 1'b1, 12'hFFF, I_CALL, 12'hFFF, I_JXX, 1'b1,
                   REG_NONE, 4'd0, 4'hE), 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int a = 0; a < STORE_NIBBLES_DEF; a++) begin
      load_nibble((a < 32) ? PRELUDE[127 - 4 * a -: 4] : 4'($urandom));
    end

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        run_program();
      end else if (r < 85) begin
        send_word(rand_stage(), 1'b0, '0);
      end else if (r < 92) begin
        load_nibble(4'($urandom));
      end else begin
        w = rand_stage();
        w.func = (r < 97) ? FUNC_RESTART : FUNC_SPARE;
        send_word(w, 1'b0, '0);
      end
    end
    start <= 1'b0;

    while (fetch_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (errs == 0 && fetch_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
